// ===== rtl/kvtc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kvtc_pkg
// Shared types and constants for the compacting key-value table.
// ---------------------------------------------------------------------------
package kvtc_pkg;

    localparam int DEPTH       = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 40;

    typedef enum logic [FUNC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // broadcast from the top to every cell
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
        logic             ins_en;
        logic             rm_en;
    } cell_cmd_t;

    // rippled from cell 0 upward
    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] first_val;
        logic [VAL_W-1:0] last_val;
    } match_chain_t;

endpackage : kvtc_pkg
`default_nettype wire

// ===== rtl/kvtc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kvtc_cell
// One table slot: holds a key/value pair, compares against the request key
// and shifts down from its upper neighbor when it or an earlier entry is removed.
// ---------------------------------------------------------------------------
module kvtc_cell (
    input  wire logic                       clk,
    input  wire logic [kvtc_pkg::IDX_W-1:0] idx,
    input  wire kvtc_pkg::cell_cmd_t        cmd,
    input  wire kvtc_pkg::match_chain_t     chain_in,
    output kvtc_pkg::match_chain_t          chain_out,
    input  wire logic [kvtc_pkg::KEY_W-1:0] up_key,
    input  wire logic [kvtc_pkg::VAL_W-1:0] up_value,
    output logic [kvtc_pkg::KEY_W-1:0]      slot_key,
    output logic [kvtc_pkg::VAL_W-1:0]      slot_value
);
    import kvtc_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic             occupied;
    logic             match;
    logic             at_tail;
    logic             shift;

    assign occupied = {1'b0, idx} < cmd.count;
    assign match    = occupied && (key_reg == cmd.key);
    assign at_tail  = {1'b0, idx} == cmd.count;
    // every slot at or above the first match takes its neighbor's pair
    assign shift    = cmd.rm_en && (chain_in.hit || match);

    always_comb
    begin
        chain_out.hit       = chain_in.hit || match;
        chain_out.first_val = chain_in.hit ? chain_in.first_val : value_reg;
        chain_out.last_val  = match ? value_reg : chain_in.last_val;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_en && at_tail)
        begin
            key_reg   <= cmd.key;
            value_reg <= cmd.value;
        end
        else if (shift)
        begin
            key_reg   <= up_key;
            value_reg <= up_value;
        end
    end

    assign slot_key   = key_reg;
    assign slot_value = value_reg;

endmodule : kvtc_cell
`default_nettype wire

// ===== rtl/key_value_table_compacting_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// key_value_table_compacting_top
// Insertion-ordered key-value table built as a row of slot cells.
// ---------------------------------------------------------------------------
//  channel  dir  tdata                               tuser
//  s_axis   in   key[31:0], value[63:32]             func[1:0]
//  m_axis   out  found_value[31:0], entry_count[36:32] status[1:0]
//
//  one beat per clock while m_axis keeps up: every cell compares in parallel and the hit ripples
//  up the row of cells in the same cycle, so a result is registered at the
//  edge that takes its request beat and is offered on m_axis the next cycle.
//  the output register holds one result; s_axis_tready is low only while
//  that result waits and m_axis_tready is low.
//  reset empties the table (entry count zero); slot contents are not cleared.
// ---------------------------------------------------------------------------
module key_value_table_compacting_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [kvtc_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // key, value
    input  wire logic [kvtc_pkg::FUNC_W-1:0]     s_axis_tuser,  // func
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [kvtc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // found_value, entry_count, pad
    output logic [kvtc_pkg::STATUS_W-1:0]        m_axis_tuser   // status
);
    import kvtc_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic [VAL_W-1:0] found_reg;
    logic [VAL_W-1:0] found_next;
    logic [CNT_W-1:0] out_count_reg;
    status_t          status_reg;
    status_t          status_next;

    logic             accept;
    logic [KEY_W-1:0] req_key;
    logic [VAL_W-1:0] req_value;
    logic             is_insert;
    logic             is_remove;
    logic             is_lookup;
    logic             full;
    logic             hit;
    cell_cmd_t        cmd;

    match_chain_t     chain [0:DEPTH];
    logic [KEY_W-1:0] link_key   [0:DEPTH];
    logic [VAL_W-1:0] link_value [0:DEPTH];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign req_key       = s_axis_tdata[KEY_W-1:0];
    assign req_value     = s_axis_tdata[KEY_W +: VAL_W];
    assign is_insert     = s_axis_tuser == OP_INSERT;
    assign is_remove     = s_axis_tuser == OP_REMOVE;
    assign is_lookup     = s_axis_tuser == OP_LOOKUP;
    assign full          = count_reg == CNT_W'(DEPTH);
    assign hit           = chain[DEPTH].hit;

    always_comb
    begin
        cmd.key    = req_key;
        cmd.value  = req_value;
        cmd.count  = count_reg;
        cmd.ins_en = accept && is_insert && !full;
        cmd.rm_en  = accept && is_remove && hit;
    end

    assign chain[0]          = '0;
    assign link_key[DEPTH]   = '0;
    assign link_value[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        kvtc_cell u_cell (
            .clk        (clk),
            .idx        (IDX_W'(i)),
            .cmd        (cmd),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1]),
            .up_key     (link_key[i+1]),
            .up_value   (link_value[i+1]),
            .slot_key   (link_key[i]),
            .slot_value (link_value[i])
        );
    end

    always_comb
    begin
        count_next  = count_reg;
        found_next  = '0;
        status_next = ST_DONE;
        if (is_insert)
        begin
            if (full)
                status_next = ST_FULL;
            else
                count_next = count_reg + CNT_W'(1);
        end
        else if (is_remove)
        begin
            if (hit)
            begin
                found_next = chain[DEPTH].first_val;
                count_next = count_reg - CNT_W'(1);
            end
            else
                status_next = ST_MISS;
        end
        else if (is_lookup)
        begin
            if (hit)
                found_next = chain[DEPTH].last_val;
            else
                status_next = ST_MISS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg     <= found_next;
            out_count_reg <= count_next;
            status_reg    <= status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - VAL_W - CNT_W){1'b0}}, out_count_reg, found_reg};
    assign m_axis_tuser  = status_reg;

    // table occupancy never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    // a full report only comes from a full table
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_FULL |-> out_count_reg == CNT_W'(DEPTH))
        else $error("full status with spare slots");

    // a miss never carries a value
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_MISS |-> found_reg == '0)
        else $error("miss with nonzero value");

    // the reported count is the table count after the beat
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_count_reg == count_reg)
        else $error("reported count differs from table count");

endmodule : key_value_table_compacting_top
`default_nettype wire
